/* sv/indexed_deque_store_top_defines.svh */
// Assertion macros for the indexed deque store.
`ifndef INDEXED_DEQUE_STORE_TOP_DEFINES_SVH
`define INDEXED_DEQUE_STORE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define IDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ids: same-cycle check failed");

`define IDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ids: next-cycle check failed");

`else

`define IDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define IDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* sv/ids_pkg.sv */
package ids_pkg;

    localparam int DEPTH_DEF = 256;

    localparam int KIND_W = 3;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 8;
    localparam int ST_W   = 2;
    localparam int ENT_W  = 9;

    typedef logic        [KIND_W-1:0] t_kind;
    typedef logic signed [VAL_W-1:0]  t_value;
    typedef logic        [POS_W-1:0]  t_pos;
    typedef logic        [ST_W-1:0]   t_status;
    typedef logic        [ENT_W-1:0]  t_count;

    localparam t_kind K_PUSH   = 3'd0;
    localparam t_kind K_POP    = 3'd1;
    localparam t_kind K_RET    = 3'd2;
    localparam t_kind K_REMOVE = 3'd3;
    localparam t_kind K_REV    = 3'd4;

    localparam t_status ST_DONE   = 2'd0;
    localparam t_status ST_EMPTY  = 2'd1;
    localparam t_status ST_FULL   = 2'd2;
    localparam t_status ST_BEYOND = 2'd3;

    localparam t_value NOT_FOUND = -32'sd1;

endpackage

/* sv/ids_cmd_if.sv */
interface ids_cmd_if;
    import ids_pkg::*;

    logic   valid;
    logic   ready;
    t_kind  kind;
    t_value value;
    t_pos   position;

    modport source (output valid, kind, value, position, input ready);
    modport sink   (input valid, kind, value, position, output ready);
endinterface

/* sv/ids_rsp_if.sv */
interface ids_rsp_if;
    import ids_pkg::*;

    logic    valid;
    logic    ready;
    t_value  read_value;
    logic    found;
    t_status status;
    t_count  entry_count;

    modport source (output valid, read_value, found, status, entry_count, input ready);
    modport sink   (input valid, read_value, found, status, entry_count, output ready);
endinterface

/* sv/ids_ram.sv */
module ids_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/indexed_deque_store_top.sv */
// channel  dir  modport  payload
// i_cmd    in   sink     kind[2:0], value[31:0] signed, position[7:0]
// o_rsp    out  source   read_value[31:0] signed, found, status[1:0], entry_count[8:0]
//
// Push, pop, retrieve, remove at index 0 and every no-op finish in the execute state, after
// the command register; retrieve reads the entry RAM through its registered read port.
// Remove at index p > 0 shifts each later entry down by one: one read, one write per shift.
// Reverse swaps entries from both ends inward: two reads and two writes per swap.
// Reset clears pointer, count and control at once; entries need no clearing pass.
// A stalled result holds in the output register; one more command may transfer, then waits.
`include "indexed_deque_store_top_defines.svh"

module indexed_deque_store_top #(
    parameter int DEPTH = ids_pkg::DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ids_cmd_if.sink  i_cmd,
    ids_rsp_if.source o_rsp
);
    import ids_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int OW = $clog2(DEPTH + 1);
    localparam int PW = (OW > POS_W) ? OW : POS_W;
    localparam logic [AW:0]   DEPTH_S  = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [OW-1:0] FULL_CNT = OW'(DEPTH);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_RM_RD = 4'd2;
    localparam logic [3:0] S_RM_WR = 4'd3;
    localparam logic [3:0] S_RV_RA = 4'd4;
    localparam logic [3:0] S_RV_RB = 4'd5;
    localparam logic [3:0] S_RV_WA = 4'd6;
    localparam logic [3:0] S_RV_WB = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [AW-1:0] x);
        logic [AW:0] s;
        s = {1'b0, base} + {1'b0, x};
        if (s >= DEPTH_S) begin
            s = s - DEPTH_S;
        end
        return s[AW-1:0];
    endfunction

    logic [3:0]    r_state, n_state;
    t_kind         r_kind;
    t_value        r_val;
    t_pos          r_pos;
    logic [AW-1:0] r_front, n_front;
    logic [OW-1:0] r_occ, n_occ;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_lo, n_lo;
    logic [AW-1:0] r_hi, n_hi;
    logic [VAL_W-1:0] r_tmp, n_tmp;

    t_value  r_res_rd;
    logic    r_res_fnd;
    t_status r_res_st;
    t_count  r_res_cnt;

    logic    r_out_valid;
    t_value  r_out_rd;
    logic    r_out_fnd;
    t_status r_out_st;
    t_count  r_out_cnt;

    logic             we;
    logic [AW-1:0]    waddr;
    logic [VAL_W-1:0] wdata;
    logic [AW-1:0]    raddr;
    logic [VAL_W-1:0] rdata;

    logic    fin;
    t_value  res_rd;
    logic    res_fnd;
    t_status res_st;

    logic          accept;
    logic          out_free;
    logic          load_out;
    logic [PW-1:0] in_pos_w;
    logic [PW-1:0] pos_w;
    logic          pos_ge;
    logic [AW-1:0] front_inc;
    logic [AW-1:0] front_dec;

    ids_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign i_cmd.ready = i_rst_n && (r_state == S_IDLE);
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;

    assign in_pos_w  = PW'(i_cmd.position);
    assign pos_w     = PW'(r_pos);
    assign pos_ge    = pos_w >= PW'(r_occ);
    assign front_inc = (r_front == LAST_IDX) ? '0 : r_front + AW'(1);
    assign front_dec = (r_front == '0) ? LAST_IDX : r_front - AW'(1);

    always_comb begin
        n_state = r_state;
        n_front = r_front;
        n_occ   = r_occ;
        n_i     = r_i;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_tmp   = r_tmp;
        we      = 1'b0;
        waddr   = r_front;
        wdata   = r_val;
        raddr   = slot(r_front, in_pos_w[AW-1:0]);
        fin     = 1'b0;
        res_rd  = '0;
        res_fnd = 1'b0;
        res_st  = ST_DONE;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_kind)
                    K_PUSH: begin
                        fin = 1'b1;
                        if (r_occ == FULL_CNT) begin
                            res_st = ST_FULL;
                        end else begin
                            we      = 1'b1;
                            waddr   = front_dec;
                            n_front = front_dec;
                            n_occ   = r_occ + OW'(1);
                        end
                    end
                    K_POP: begin
                        fin = 1'b1;
                        if (r_occ == '0) begin
                            res_st = ST_EMPTY;
                        end else begin
                            n_occ   = r_occ - OW'(1);
                            n_front = (r_occ == OW'(1)) ? '0 : front_inc;
                        end
                    end
                    K_RET: begin
                        fin = 1'b1;
                        if (r_occ == '0) begin
                            res_st = ST_EMPTY;
                            res_rd = NOT_FOUND;
                        end else if (pos_ge) begin
                            res_st = ST_BEYOND;
                            res_rd = NOT_FOUND;
                        end else begin
                            res_rd  = $signed(rdata);
                            res_fnd = 1'b1;
                        end
                    end
                    K_REMOVE: begin
                        if (r_occ == '0) begin
                            fin    = 1'b1;
                            res_st = ST_EMPTY;
                        end else if (pos_ge) begin
                            fin    = 1'b1;
                            res_st = ST_BEYOND;
                        end else if (r_pos == '0) begin
                            fin     = 1'b1;
                            n_occ   = r_occ - OW'(1);
                            n_front = (r_occ == OW'(1)) ? '0 : front_inc;
                        end else begin
                            n_i     = pos_w[AW-1:0];
                            n_state = S_RM_RD;
                        end
                    end
                    K_REV: begin
                        if (r_occ == '0) begin
                            fin    = 1'b1;
                            res_st = ST_EMPTY;
                        end else begin
                            n_lo    = '0;
                            n_hi    = AW'(r_occ - OW'(1));
                            n_state = S_RV_RA;
                        end
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end
            S_RM_RD: begin
                if ((OW'(r_i) + OW'(1)) < r_occ) begin
                    raddr   = slot(r_front, r_i + AW'(1));
                    n_state = S_RM_WR;
                end else begin
                    fin   = 1'b1;
                    n_occ = r_occ - OW'(1);
                end
            end
            S_RM_WR: begin
                we      = 1'b1;
                waddr   = slot(r_front, r_i);
                wdata   = rdata;
                n_i     = r_i + AW'(1);
                n_state = S_RM_RD;
            end
            S_RV_RA: begin
                if (r_lo < r_hi) begin
                    raddr   = slot(r_front, r_lo);
                    n_state = S_RV_RB;
                end else begin
                    fin = 1'b1;
                end
            end
            S_RV_RB: begin
                raddr   = slot(r_front, r_hi);
                n_tmp   = rdata;
                n_state = S_RV_WA;
            end
            S_RV_WA: begin
                we      = 1'b1;
                waddr   = slot(r_front, r_lo);
                wdata   = rdata;
                n_state = S_RV_WB;
            end
            S_RV_WB: begin
                we      = 1'b1;
                waddr   = slot(r_front, r_hi);
                wdata   = r_tmp;
                n_lo    = r_lo + AW'(1);
                n_hi    = r_hi - AW'(1);
                n_state = S_RV_RA;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_state = out_free ? S_IDLE : S_OUT;
        end
    end

    assign load_out = (fin || (r_state == S_OUT)) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_occ   <= n_occ;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_cmd.kind;
            r_val  <= i_cmd.value;
            r_pos  <= i_cmd.position;
        end
        r_i   <= n_i;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_tmp <= n_tmp;
        if (fin) begin
            r_res_rd  <= res_rd;
            r_res_fnd <= res_fnd;
            r_res_st  <= res_st;
            r_res_cnt <= t_count'(n_occ);
        end
        if (load_out) begin
            r_out_rd  <= fin ? res_rd : r_res_rd;
            r_out_fnd <= fin ? res_fnd : r_res_fnd;
            r_out_st  <= fin ? res_st : r_res_st;
            r_out_cnt <= fin ? t_count'(n_occ) : r_res_cnt;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_value  = r_out_rd;
    assign o_rsp.found       = r_out_fnd;
    assign o_rsp.status      = r_out_st;
    assign o_rsp.entry_count = r_out_cnt;

    `IDS_ASSERT_IMP(a_occ_bound, i_clk, i_rst_n, 1'b1, r_occ <= FULL_CNT)
    `IDS_ASSERT_IMP(a_front_empty, i_clk, i_rst_n, r_occ == '0, r_front == '0)
    `IDS_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, accept, r_state != S_IDLE)
    `IDS_ASSERT_IMP(a_found_done, i_clk, i_rst_n, o_rsp.valid && o_rsp.found, o_rsp.status == ST_DONE)
    `IDS_ASSERT_IMP(a_full_count, i_clk, i_rst_n, o_rsp.valid && o_rsp.status == ST_FULL, o_rsp.entry_count == t_count'(DEPTH))
endmodule

/* test/tb_indexed_deque_store_top.sv */
`timescale 1ns / 100ps

import ids_pkg::*;

typedef struct {
    t_value  read_value;
    logic    found;
    t_status status;
    t_count  entry_count;
} t_store_answer;

class store_scoreboard;
    localparam int RING = DEPTH_DEF;

    t_value        ring [RING];
    int unsigned   front;
    int unsigned   held;
    int            noted_count;
    int            mismatch_count;
    t_store_answer awaited_answers [$];

    function new();
        front = 0;
        held = 0;
        noted_count = 0;
        mismatch_count = 0;
    endfunction

    function int unsigned slot(int unsigned index);
        return (front + index) % RING;
    endfunction

    function void drop_front();
        front = (front + 1) % RING;
        held--;
        if (held == 0) front = 0;
    endfunction

    function t_store_answer apply_command(t_kind kind, t_value value, t_pos position);
        t_store_answer ans;
        int unsigned   lo;
        int unsigned   hi;
        int unsigned   i;
        t_value        swap;
        ans.read_value = '0;
        ans.found = 1'b0;
        ans.status = ST_DONE;
        case (kind)
            K_PUSH: begin
                if (held >= RING) begin
                    ans.status = ST_FULL;
                end else begin
                    front = (front + RING - 1) % RING;
                    ring[front] = value;
                    held++;
                end
            end
            K_POP: begin
                if (held == 0) ans.status = ST_EMPTY;
                else drop_front();
            end
            K_RET: begin
                if (held == 0) begin
                    ans.status = ST_EMPTY;
                    ans.read_value = NOT_FOUND;
                end else if (int'(position) >= held) begin
                    ans.status = ST_BEYOND;
                    ans.read_value = NOT_FOUND;
                end else begin
                    ans.read_value = ring[slot(position)];
                    ans.found = 1'b1;
                end
            end
            K_REMOVE: begin
                if (held == 0) begin
                    ans.status = ST_EMPTY;
                end else if (int'(position) >= held) begin
                    ans.status = ST_BEYOND;
                end else if (position == 0) begin
                    drop_front();
                end else begin
                    for (i = position; i + 1 < held; i++)
                        ring[slot(i)] = ring[slot(i + 1)];
                    held--;
                end
            end
            K_REV: begin
                if (held == 0) begin
                    ans.status = ST_EMPTY;
                end else begin
                    lo = 0;
                    hi = held - 1;
                    while (lo < hi) begin
                        swap = ring[slot(lo)];
                        ring[slot(lo)] = ring[slot(hi)];
                        ring[slot(hi)] = swap;
                        lo++;
                        hi--;
                    end
                end
            end
            default: ;
        endcase
        ans.entry_count = t_count'(held);
        return ans;
    endfunction

    function void note_command(t_kind kind, t_value value, t_pos position);
        awaited_answers.push_back(apply_command(kind, value, position));
        noted_count++;
    endfunction

    task report_mismatch(string what);
        mismatch_count++;
        $display("mismatch: %s", what);
    endtask

    task check_answer(t_store_answer got);
        t_store_answer want;
        if (awaited_answers.size() == 0) begin
            report_mismatch("answer with no command waiting");
            return;
        end
        want = awaited_answers.pop_front();
        if (got.read_value !== want.read_value)
            report_mismatch($sformatf("read_value %0d, want %0d",
                                      got.read_value, want.read_value));
        if (got.found !== want.found)
            report_mismatch($sformatf("found %b, want %b", got.found, want.found));
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count %0d, want %0d",
                                      got.entry_count, want.entry_count));
    endtask
endclass

module tb_indexed_deque_store_top;
    localparam int RANDOM_ITEMS = 880;
    localparam int IDLE_PCT     = 37;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 600;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int KIND_TOP     = (1 << KIND_W) - 1;

    typedef enum {FILLING, DRAINING, MIXING} t_traffic_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic steady;
    int   cycle_count;
    int   hold_left;
    logic hold_done;

    store_scoreboard sb = new();

    ids_cmd_if cmd_ch();
    ids_rsp_if rsp_ch();

    indexed_deque_store_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        i_rst_n = 1'b0;
        steady = 1'b0;
        cycle_count = 0;
        hold_left = 0;
        hold_done = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.kind = K_PUSH;
        cmd_ch.value = '0;
        cmd_ch.position = '0;
        rsp_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_store_answer got;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.read_value = rsp_ch.read_value;
            got.found = rsp_ch.found;
            got.status = rsp_ch.status;
            got.entry_count = rsp_ch.entry_count;
            sb.check_answer(got);
        end
    end

    // hold off once for a long stretch so the block backs up into its input
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end else if (!hold_done && sb.noted_count >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task send_command(t_kind kind, t_value value, t_pos position);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.kind <= kind;
        cmd_ch.value <= value;
        cmd_ch.position <= position;
        do @(posedge i_clk); while (!cmd_ch.ready);
        sb.note_command(kind, value, position);
    endtask

    function t_value pick_value();
        case ($urandom_range(0, 15))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -32'sd1;
            3: return 32'sd0;
            default: return t_value'($urandom);
        endcase
    endfunction

    function t_pos pick_position();
        if (sb.held > 0 && $urandom_range(0, 99) < 75)
            return t_pos'($urandom_range(0, sb.held - 1));
        return t_pos'($urandom_range(0, 255));
    endfunction

    function t_kind pick_kind(t_traffic_mode mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            FILLING: begin
                if (r < 85) return K_PUSH;
                if (r < 93) return K_RET;
                if (r < 95) return K_POP;
                if (r < 97) return K_REMOVE;
                if (r < 99) return K_REV;
            end
            DRAINING: begin
                if (r < 8)  return K_PUSH;
                if (r < 20) return K_RET;
                if (r < 60) return K_POP;
                if (r < 90) return K_REMOVE;
                if (r < 97) return K_REV;
            end
            default: begin
                if (r < 30) return K_PUSH;
                if (r < 50) return K_RET;
                if (r < 70) return K_POP;
                if (r < 85) return K_REMOVE;
                if (r < 95) return K_REV;
            end
        endcase
        return t_kind'($urandom_range(int'(K_REV) + 1, KIND_TOP));
    endfunction

    initial begin
        t_traffic_mode mode;
        int n;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_command(K_RET, 32'sd0, 8'd0);
        send_command(K_POP, 32'sd0, 8'd0);
        send_command(K_REMOVE, 32'sd0, 8'd0);
        send_command(K_REV, 32'sd0, 8'd0);
        send_command(K_PUSH, 32'sh8000_0000, 8'd0);
        send_command(K_REV, 32'sd0, 8'd0);
        send_command(K_RET, 32'sd0, 8'd0);
        send_command(K_RET, 32'sd0, 8'd1);
        send_command(K_POP, 32'sd0, 8'd0);
        send_command(K_PUSH, 32'sh7fff_ffff, 8'd255);
        send_command(K_PUSH, -32'sd1, 8'd0);
        send_command(K_PUSH, 32'sd0, 8'd0);
        send_command(K_PUSH, 32'sh5a5a_a5a5, 8'd0);
        send_command(K_RET, 32'sd0, 8'd255);
        send_command(K_RET, 32'sd0, 8'd3);
        send_command(K_REMOVE, 32'sd0, 8'd3);
        send_command(K_REMOVE, 32'sd0, 8'd1);
        send_command(K_REMOVE, 32'sd0, 8'd5);
        send_command(K_REV, 32'sd0, 8'd0);
        send_command(K_RET, 32'sd0, 8'd1);
        send_command(K_REMOVE, 32'sd0, 8'd0);
        send_command(K_REMOVE, 32'sd0, 8'd0);
        send_command(t_kind'(int'(K_REV) + 1), -32'sd1, 8'd255);
        send_command(t_kind'(int'(K_REV) + 2), 32'sh1234_5678, 8'd0);
        send_command(t_kind'(KIND_TOP), 32'sh8000_0000, 8'd128);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            mode = (n < 350) ? FILLING : ((n < 650) ? DRAINING : MIXING);
            steady = (n >= 500 && n < 650);
            send_command(pick_kind(mode), pick_value(), pick_position());
        end
        steady = 1'b0;
        @(negedge i_clk);
        cmd_ch.valid <= 1'b0;

        while (sb.awaited_answers.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+sv
sv/ids_pkg.sv
sv/ids_cmd_if.sv
sv/ids_rsp_if.sv
sv/ids_ram.sv
sv/indexed_deque_store_top.sv
test/tb_indexed_deque_store_top.sv
